### hdl/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 8;

    localparam int          CAP_BITS  = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

### hdl/sorted_priority_queue.sv
// sorted priority queue: row of compare-and-shift cells with a registered result
// result: a result word is registered and appears on m_ in the cycle after its input word is accepted
// throughput: one enqueue or dequeue per cycle while m_ is not stalled; every cell compares against the
//   new key and shifts in the same cycle, so no operation waits on the cells
// reset: all cells empty, count zero, capacity 16; stored keys and handles are not cleared
module sorted_priority_queue #(
    parameter int DEPTH       = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS    = spq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF,
    localparam int COUNT_BITS = $clog2(DEPTH + 1),
    localparam int IN_W       = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((KEY_BITS + HANDLE_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // new_key, new_handle
    input  logic [0:0]                    s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,   // out_key, out_handle, entry_count
    output logic [2:0]                    m_tuser,   // out_valid, status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spq_pkg::CAP_BITS-1:0]  cfg_data
);

    localparam int CMP_BITS = (COUNT_BITS > spq_pkg::CAP_BITS) ?
                              COUNT_BITS : spq_pkg::CAP_BITS;

    logic [spq_pkg::CAP_BITS-1:0] capacity_reg;
    logic [COUNT_BITS-1:0]        count_reg, count_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [KEY_BITS-1:0]          out_key_reg, out_key_next;
    logic [HANDLE_BITS-1:0]       out_handle_reg, out_handle_next;
    logic                         out_valid_reg, out_valid_next;
    spq_pkg::status_t             status_reg, status_next;
    logic [COUNT_BITS-1:0]        entry_count_reg;

    logic                         fire;
    spq_pkg::op_t                 op;
    logic [KEY_BITS-1:0]          in_key;
    logic [HANDLE_BITS-1:0]       in_handle;
    logic                         full;
    logic                         empty;
    spq_pkg::cell_ctrl_t          ctrl;

    logic                         cell_ge     [DEPTH];
    logic                         cell_valid  [DEPTH];
    logic [KEY_BITS-1:0]          cell_key    [DEPTH];
    logic [HANDLE_BITS-1:0]       cell_handle [DEPTH];
    logic [DEPTH-1:0]             valid_vec;
    logic [DEPTH-1:0]             thermo_vec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign fire      = s_tvalid && s_tready;
    assign op        = spq_pkg::op_t'(s_tuser[0]);
    assign in_key    = s_tdata[KEY_BITS-1:0];
    assign in_handle = s_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS];

    // capacity above the built depth saturates at the depth
    assign full  = (CMP_BITS'(count_reg) >= CMP_BITS'(capacity_reg)) ||
                   (CMP_BITS'(count_reg) >= CMP_BITS'(DEPTH));
    assign empty = (count_reg == '0);

    assign ctrl.enq = fire && (op == spq_pkg::OP_ENQ) && !full;
    assign ctrl.deq = fire && (op == spq_pkg::OP_DEQ) && !empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                   l_ge, l_valid, r_valid;
        logic [KEY_BITS-1:0]    l_key, r_key;
        logic [HANDLE_BITS-1:0] l_handle, r_handle;

        if (i == 0) begin : g_head
            assign l_ge     = 1'b1;
            assign l_valid  = 1'b0;
            assign l_key    = '0;
            assign l_handle = '0;
        end else begin : g_body
            assign l_ge     = cell_ge[i-1];
            assign l_valid  = cell_valid[i-1];
            assign l_key    = cell_key[i-1];
            assign l_handle = cell_handle[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign r_valid  = 1'b0;
            assign r_key    = '0;
            assign r_handle = '0;
        end else begin : g_inner
            assign r_valid  = cell_valid[i+1];
            assign r_key    = cell_key[i+1];
            assign r_handle = cell_handle[i+1];
        end

        spq_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .new_key      (in_key),
            .new_handle   (in_handle),
            .left_ge      (l_ge),
            .left_valid   (l_valid),
            .left_key     (l_key),
            .left_handle  (l_handle),
            .right_valid  (r_valid),
            .right_key    (r_key),
            .right_handle (r_handle),
            .ge           (cell_ge[i]),
            .valid        (cell_valid[i]),
            .key          (cell_key[i]),
            .handle       (cell_handle[i])
        );

        assign valid_vec[i]  = cell_valid[i];
        assign thermo_vec[i] = (COUNT_BITS'(i) < count_reg);
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.enq) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.deq) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        out_key_next    = '0;
        out_handle_next = '0;
        out_valid_next  = 1'b0;
        status_next     = spq_pkg::ST_OK;
        if (ctrl.deq) begin
            out_key_next    = cell_key[0];
            out_handle_next = cell_handle[0];
            out_valid_next  = 1'b1;
        end else if (op == spq_pkg::OP_ENQ && full) begin
            status_next = spq_pkg::ST_FULL;
        end else if (op == spq_pkg::OP_DEQ && empty) begin
            status_next = spq_pkg::ST_EMPTY;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= spq_pkg::CAP_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_key_reg     <= out_key_next;
            out_handle_reg  <= out_handle_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            entry_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({entry_count_reg, out_handle_reg, out_key_reg});
    assign m_tuser  = {status_reg, out_valid_reg};

    // live cells always form a solid run from the head
    a_valid_thermo: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_vec == thermo_vec)
        else $error("cell valid bits disagree with count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_BITS'(count_reg) <= CMP_BITS'(DEPTH))
        else $error("count above depth");

    a_deq_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && op == spq_pkg::OP_DEQ && !empty) |=> (m_tvalid && m_tuser[0]))
        else $error("dequeue of a live entry gave no entry");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && op == spq_pkg::OP_ENQ && full) |=> $stable(count_reg))
        else $error("rejected enqueue changed the count");

endmodule

### hdl/spq_cell.sv
// one slot of the sorted queue: holds an entry and shifts left or right
module spq_cell #(
    parameter int KEY_BITS    = spq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  spq_pkg::cell_ctrl_t     ctrl,
    input  logic [KEY_BITS-1:0]     new_key,
    input  logic [HANDLE_BITS-1:0]  new_handle,
    input  logic                    left_ge,
    input  logic                    left_valid,
    input  logic [KEY_BITS-1:0]     left_key,
    input  logic [HANDLE_BITS-1:0]  left_handle,
    input  logic                    right_valid,
    input  logic [KEY_BITS-1:0]     right_key,
    input  logic [HANDLE_BITS-1:0]  right_handle,
    output logic                    ge,
    output logic                    valid,
    output logic [KEY_BITS-1:0]     key,
    output logic [HANDLE_BITS-1:0]  handle
);

    logic                   valid_reg, valid_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;

    // entry stays ahead of a new key that is not larger
    assign ge = valid_reg && (key_reg >= new_key);

    always_comb begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctrl.deq) begin
            valid_next  = right_valid;
            key_next    = right_key;
            handle_next = right_handle;
        end else if (ctrl.enq && !ge) begin
            if (left_ge) begin
                // insertion point
                valid_next  = 1'b1;
                key_next    = new_key;
                handle_next = new_handle;
            end else begin
                valid_next  = left_valid;
                key_next    = left_key;
                handle_next = left_handle;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign valid  = valid_reg;
    assign key    = key_reg;
    assign handle = handle_reg;

endmodule

### verif/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted priority queue: directed and random enqueue/dequeue traffic
module tb_sorted_priority_queue;

    localparam int DEPTH       = 16;
    localparam int KEY_W       = 16;
    localparam int HANDLE_W    = 8;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        spq_pkg::op_t        op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } queue_op_t;

    typedef struct {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic                valid;
        spq_pkg::status_t    status;
        logic [4:0]          count;
    } queue_result_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic [IN_W-1:0]              s_tdata   = '0;
    logic [0:0]                   s_tuser   = '0;
    logic                         m_tready  = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic [spq_pkg::CAP_BITS-1:0] cfg_data  = '0;
    wire                          s_tready;
    wire                          m_tvalid;
    wire  [OUT_W-1:0]             m_tdata;
    wire  [2:0]                   m_tuser;
    wire                          cfg_ready;

    sorted_priority_queue DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // new_key, new_handle
        .s_tuser   (s_tuser),     // opcode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // out_key, out_handle, entry_count
        .m_tuser   (m_tuser),     // out_valid, status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the sorted entries
    logic [KEY_W-1:0]    shadow_keys    [DEPTH];
    logic [HANDLE_W-1:0] shadow_handles [DEPTH];
    int unsigned         shadow_count    = 0;
    logic [4:0]          shadow_capacity = spq_pkg::CAP_RESET;

    queue_op_t     op_backlog[$];
    queue_result_t expected_results[$];

    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned enq_ok       = 0;
    int unsigned deq_ok       = 0;
    int unsigned full_rejects = 0;
    int unsigned empty_rejects = 0;
    int unsigned peak_count   = 0;
    int unsigned caps_written = 0;
    int unsigned holds_done   = 0;
    int unsigned cycles       = 0;

    function automatic queue_result_t apply_queue_op(queue_op_t item);
        queue_result_t r;
        int unsigned   cap;
        int unsigned   pos;
        r.key    = '0;
        r.handle = '0;
        r.valid  = 1'b0;
        r.status = spq_pkg::ST_OK;
        cap = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
        if (item.op == spq_pkg::OP_ENQ) begin
            if (shadow_count >= cap) begin
                r.status = spq_pkg::ST_FULL;
                full_rejects++;
            end else begin
                // stable insert: after every entry with a key >= the new key
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] >= item.key)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_keys[i]    = shadow_keys[i-1];
                    shadow_handles[i] = shadow_handles[i-1];
                end
                shadow_keys[pos]    = item.key;
                shadow_handles[pos] = item.handle;
                shadow_count++;
                enq_ok++;
                if (shadow_count > peak_count)
                    peak_count = shadow_count;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = spq_pkg::ST_EMPTY;
                empty_rejects++;
            end else begin
                r.key    = shadow_keys[0];
                r.handle = shadow_handles[0];
                r.valid  = 1'b1;
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_keys[i-1]    = shadow_keys[i];
                    shadow_handles[i-1] = shadow_handles[i];
                end
                shadow_count--;
                deq_ok++;
            end
        end
        r.count = shadow_count[4:0];
        return r;
    endfunction

    // sender: bursts of words with random gaps
    queue_op_t   accepted_op;
    queue_op_t   next_op;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted_op.op     = spq_pkg::op_t'(s_tuser[0]);
                accepted_op.key    = s_tdata[15:0];
                accepted_op.handle = s_tdata[23:16];
                expected_results.push_back(apply_queue_op(accepted_op));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    next_op = op_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_op.op;
                    s_tdata  <= {next_op.handle, next_op.key};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                                  : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern in modes, plus long hold-offs to back up the queue
    int unsigned rx_mode      = 0;
    int unsigned mode_left    = 0;
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 250;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (results_seen >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += 700;
            holds_done++;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 9) < 8);
                default: m_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    queue_result_t want_r;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, actual tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
            end else begin
                want_r = expected_results.pop_front();
                check_field("out_key",     want_r.key,    m_tdata[15:0]);
                check_field("out_handle",  want_r.handle, m_tdata[23:16]);
                check_field("entry_count", want_r.count,  m_tdata[28:24]);
                check_field("out_valid",   want_r.valid,  m_tuser[0]);
                check_field("status",      want_r.status, m_tuser[2:1]);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still expected", $time,
                     expected_results.size());
            $display("sorted_priority_queue test failed");
            $finish;
        end
    end

    task automatic push_op(input spq_pkg::op_t op, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle);
        queue_op_t item;
        item.op     = op;
        item.key    = key;
        item.handle = handle;
        op_backlog.push_back(item);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (op_backlog.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        shadow_capacity = value;
        caps_written++;
    endtask

    task automatic random_phase(input logic [4:0] cap, input int unsigned count,
                                input int unsigned enq_pct);
        logic [KEY_W-1:0] k;
        wait_drained();
        write_capacity(cap);
        repeat (count) begin
            if ($urandom_range(0, 99) < enq_pct) begin
                case ($urandom_range(0, 9))
                    0:       k = '0;
                    1:       k = '1;
                    2, 3, 4: k = KEY_W'($urandom_range(0, 7));   // lots of equal keys
                    default: k = KEY_W'($urandom);
                endcase
                push_op(spq_pkg::OP_ENQ, k, HANDLE_W'($urandom));
            end else begin
                // payload of a dequeue word is don't-care noise
                push_op(spq_pkg::OP_DEQ, KEY_W'($urandom), HANDLE_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset capacity: empty dequeue, key extremes, ties kept in arrival order
        push_op(spq_pkg::OP_DEQ, 16'h0000, 8'h00);
        push_op(spq_pkg::OP_ENQ, 16'h0000, 8'h00);
        push_op(spq_pkg::OP_ENQ, 16'hFFFF, 8'hFF);
        push_op(spq_pkg::OP_ENQ, 16'h1234, 8'h01);
        push_op(spq_pkg::OP_ENQ, 16'h1234, 8'h02);
        push_op(spq_pkg::OP_ENQ, 16'h0000, 8'h7F);
        push_op(spq_pkg::OP_ENQ, 16'h1234, 8'h03);
        repeat (7) push_op(spq_pkg::OP_DEQ, 16'hFFFF, 8'hFF);

        // small capacity: full rejection
        wait_drained();
        write_capacity(5'd2);
        push_op(spq_pkg::OP_ENQ, 16'h8000, 8'h80);
        push_op(spq_pkg::OP_ENQ, 16'h8000, 8'h81);
        push_op(spq_pkg::OP_ENQ, 16'hFFFF, 8'h01);

        // capacity dropped under the live count: no entry lost, enqueues refused while the count is at or above it
        wait_drained();
        write_capacity(5'd1);
        push_op(spq_pkg::OP_ENQ, 16'h0001, 8'h02);
        push_op(spq_pkg::OP_DEQ, 16'h0000, 8'h00);
        push_op(spq_pkg::OP_ENQ, 16'h0002, 8'h03);
        push_op(spq_pkg::OP_DEQ, 16'h0000, 8'h00);
        push_op(spq_pkg::OP_ENQ, 16'h00FF, 8'h55);

        // zero capacity: every enqueue is refused as full
        wait_drained();
        write_capacity(5'd0);
        push_op(spq_pkg::OP_ENQ, 16'hAAAA, 8'hAA);
        push_op(spq_pkg::OP_DEQ, 16'h5555, 8'h55);
        push_op(spq_pkg::OP_DEQ, 16'h0000, 8'h00);

        random_phase(5'd31, 200, 60);   // saturates to the built depth
        random_phase(5'd16, 200, 50);
        random_phase(5'd1,  200, 50);
        random_phase(5'd5,  200, 65);
        random_phase(5'd17, 200, 75);
        random_phase(5'd0,  200, 40);
        random_phase(5'd8,  200, 35);
        random_phase(5'($urandom_range(1, 31)), 200, 55);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, expected_results.size());
        end

        $display("covered %0d words: %0d enqueued, %0d dequeued, %0d refused full, %0d refused empty",
                 results_seen, enq_ok, deq_ok, full_rejects, empty_rejects);
        $display("peak occupancy %0d, %0d capacity writes, %0d long output stalls, %0d errors",
                 peak_count, caps_written, holds_done, errors);
        if (errors == 0) begin
            $display("sorted_priority_queue test passed");
        end else begin
            $display("sorted_priority_queue test failed");
        end
        $finish;
    end

endmodule
